>>> hdl/tpew_pkg.sv
// types, constants and microcode program of the eight-way trilinear panner
package tpew_pkg;

   // fixed-point constants
   localparam logic [16:0] POS_ONE = 17'h10000;
   localparam int STEP_W = 5;
   localparam int ACC_W = 20;

   // register indexes on the configuration port
   typedef enum logic [2:0] {
      REG_X_BASE,
      REG_Y_BASE,
      REG_Z_BASE,
      REG_X_AMOUNT,
      REG_Y_AMOUNT,
      REG_Z_AMOUNT,
      REG_OUT_LEVEL,
      REG_MONO_SUM
   } reg_idx_type;

   // multiplier operand a
   typedef enum logic [3:0] {
      A_NONE,
      A_CVX,
      A_CVY,
      A_CVZ,
      A_AUDIO,
      A_WX0,
      A_WX1,
      A_S,
      A_U0,
      A_U1
   } mul_a_type;

   // multiplier operand b
   typedef enum logic [3:0] {
      B_NONE,
      B_AX,
      B_AY,
      B_AZ,
      B_LVL,
      B_WY0,
      B_WY1,
      B_WZ0,
      B_WZ1,
      B_WXY0,
      B_WXY1,
      B_WXY2,
      B_WXY3
   } mul_b_type;

   // write-back of the registered product
   typedef enum logic [2:0] {
      WB_NONE,
      WB_POS,
      WB_SCALE,
      WB_WXY,
      WB_U,
      WB_CORNER
   } wb_op_type;

   // sequencing condition of a step
   typedef enum logic [1:0] {
      COND_NONE,
      COND_ITEM,
      COND_PUBLISH
   } cond_type;

   // one control word
   typedef struct packed {
      mul_a_type   mul_a;
      mul_b_type   mul_b;
      wb_op_type   wb;
      logic [2:0]  wb_idx;
      logic        acc_en;
      logic [2:0]  acc_idx;
      cond_type    cond;
   } ucode_type;

   // microcode program, one word per step
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '{A_NONE, B_NONE, WB_NONE, 3'd0, 1'b0, 3'd0, COND_NONE};
      unique case (step)
         5'd0:  w.cond = COND_ITEM;
         5'd1:  begin w.mul_a = A_CVX; w.mul_b = B_AX; end
         5'd2:  begin w.mul_a = A_CVY; w.mul_b = B_AY; w.wb = WB_POS; w.wb_idx = 3'd0; end
         5'd3:  begin w.mul_a = A_CVZ; w.mul_b = B_AZ; w.wb = WB_POS; w.wb_idx = 3'd1; end
         5'd4:  begin w.mul_a = A_AUDIO; w.mul_b = B_LVL; w.wb = WB_POS; w.wb_idx = 3'd2; end
         5'd5:  begin w.mul_a = A_WX0; w.mul_b = B_WY0; w.wb = WB_SCALE; end
         5'd6:  begin w.mul_a = A_WX1; w.mul_b = B_WY0; w.wb = WB_WXY; w.wb_idx = 3'd0; end
         5'd7:  begin w.mul_a = A_WX0; w.mul_b = B_WY1; w.wb = WB_WXY; w.wb_idx = 3'd1; end
         5'd8:  begin w.mul_a = A_WX1; w.mul_b = B_WY1; w.wb = WB_WXY; w.wb_idx = 3'd2; end
         5'd9:  begin w.mul_a = A_S; w.mul_b = B_WZ0; w.wb = WB_WXY; w.wb_idx = 3'd3; end
         5'd10: begin w.mul_a = A_S; w.mul_b = B_WZ1; w.wb = WB_U; w.wb_idx = 3'd0; end
         5'd11: begin w.mul_a = A_U0; w.mul_b = B_WXY0; w.wb = WB_U; w.wb_idx = 3'd1; end
         5'd12: begin
            w.mul_a = A_U0; w.mul_b = B_WXY1; w.wb = WB_CORNER; w.wb_idx = 3'd0;
         end
         5'd13: begin
            w.mul_a = A_U0; w.mul_b = B_WXY2; w.wb = WB_CORNER; w.wb_idx = 3'd1;
            w.acc_en = 1'b1; w.acc_idx = 3'd0;
         end
         5'd14: begin
            w.mul_a = A_U0; w.mul_b = B_WXY3; w.wb = WB_CORNER; w.wb_idx = 3'd2;
            w.acc_en = 1'b1; w.acc_idx = 3'd1;
         end
         5'd15: begin
            w.mul_a = A_U1; w.mul_b = B_WXY0; w.wb = WB_CORNER; w.wb_idx = 3'd3;
            w.acc_en = 1'b1; w.acc_idx = 3'd2;
         end
         5'd16: begin
            w.mul_a = A_U1; w.mul_b = B_WXY1; w.wb = WB_CORNER; w.wb_idx = 3'd4;
            w.acc_en = 1'b1; w.acc_idx = 3'd3;
         end
         5'd17: begin
            w.mul_a = A_U1; w.mul_b = B_WXY2; w.wb = WB_CORNER; w.wb_idx = 3'd5;
            w.acc_en = 1'b1; w.acc_idx = 3'd4;
         end
         5'd18: begin
            w.mul_a = A_U1; w.mul_b = B_WXY3; w.wb = WB_CORNER; w.wb_idx = 3'd6;
            w.acc_en = 1'b1; w.acc_idx = 3'd5;
         end
         5'd19: begin
            w.wb = WB_CORNER; w.wb_idx = 3'd7; w.acc_en = 1'b1; w.acc_idx = 3'd6;
         end
         5'd20: begin w.acc_en = 1'b1; w.acc_idx = 3'd7; end
         5'd21: w.cond = COND_PUBLISH;
         default: w.cond = COND_ITEM;
      endcase
      return w;
   endfunction

endpackage

>>> hdl/trilinear_panner_eight_way_unit.sv
// eight-way trilinear amplitude panner, microcoded around one shared multiplier
// an item runs the program from accept to result valid, at most one multiply per step
// a new item is taken only after the last one is published, which waits on a result stall
// the program has 22 steps and runs on the single 34x18 multiplier
// reset: synchronous, active high; registers take their defaults, sums clear
// a mono frame gives one result on its last channel, other channels give none
module trilinear_panner_eight_way_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_audio_in,
   input  logic signed [15:0] req_x_cv,
   input  logic signed [15:0] req_y_cv,
   input  logic signed [15:0] req_z_cv,
   input  logic               req_last_channel,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_bottom_left_front,
   output logic signed [15:0] rsp_bottom_right_front,
   output logic signed [15:0] rsp_top_left_front,
   output logic signed [15:0] rsp_top_right_front,
   output logic signed [15:0] rsp_bottom_left_back,
   output logic signed [15:0] rsp_bottom_right_back,
   output logic signed [15:0] rsp_top_left_back,
   output logic signed [15:0] rsp_top_right_back,
   output logic               rsp_frame_end,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import tpew_pkg::*;

   // configuration registers
   logic [15:0]        x_base_ff, y_base_ff, z_base_ff, out_level_ff;
   logic signed [15:0] x_amount_ff, y_amount_ff, z_amount_ff;
   logic               mono_ff;

   // captured item
   logic signed [15:0] audio_ff, x_cv_ff, y_cv_ff, z_cv_ff;
   logic               last_ff;

   // sequencer
   logic [STEP_W-1:0]  step_ff, step_in;
   ucode_type          uc;

   // datapath registers
   logic signed [51:0] prod_ff, prod_in;
   logic [16:0]        px_ff, py_ff, pz_ff;
   logic signed [16:0] s_ff;
   logic [16:0]        wxy_ff [4];
   logic signed [33:0] u_ff [2];
   logic signed [15:0] c_ff;
   logic signed [ACC_W-1:0] acc_ff [8];
   logic signed [15:0] res_ff [8];

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] out_ff [8];
   logic               frame_end_ff;

   logic               cfg_wr;
   logic               req_accept;
   logic               rsp_free;
   logic               produce;
   logic               publish;

   logic [16:0]        wx0, wy0, wz0;
   logic signed [33:0] a_op;
   logic signed [17:0] b_op;

   logic signed [51:0] bias;
   logic signed [51:0] rnd_sum;
   logic signed [51:0] sh14, sh16, sh32;
   logic [15:0]        base_sel;
   logic signed [18:0] pos_sum;
   logic [16:0]        pos_in;
   logic signed [19:0] corner_raw;
   logic signed [15:0] c_in;
   logic signed [20:0] acc_sum;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [15:0] res_in;
   logic               res_we;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         x_base_ff    <= 16'd32768;
         y_base_ff    <= 16'd32768;
         z_base_ff    <= 16'd32768;
         x_amount_ff  <= '0;
         y_amount_ff  <= '0;
         z_amount_ff  <= '0;
         out_level_ff <= 16'hFFFF;
         mono_ff      <= 1'b0;
      end else if (cfg_wr) begin
         unique case (reg_idx_type'(paddr[4:2]))
            REG_X_BASE:    x_base_ff    <= pwdata[15:0];
            REG_Y_BASE:    y_base_ff    <= pwdata[15:0];
            REG_Z_BASE:    z_base_ff    <= pwdata[15:0];
            REG_X_AMOUNT:  x_amount_ff  <= pwdata[15:0];
            REG_Y_AMOUNT:  y_amount_ff  <= pwdata[15:0];
            REG_Z_AMOUNT:  z_amount_ff  <= pwdata[15:0];
            REG_OUT_LEVEL: out_level_ff <= pwdata[15:0];
            REG_MONO_SUM:  mono_ff      <= pwdata[0];
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (reg_idx_type'(paddr[4:2]))
         REG_X_BASE:    prdata = {16'd0, x_base_ff};
         REG_Y_BASE:    prdata = {16'd0, y_base_ff};
         REG_Z_BASE:    prdata = {16'd0, z_base_ff};
         REG_X_AMOUNT:  prdata = {16'd0, x_amount_ff};
         REG_Y_AMOUNT:  prdata = {16'd0, y_amount_ff};
         REG_Z_AMOUNT:  prdata = {16'd0, z_amount_ff};
         REG_OUT_LEVEL: prdata = {16'd0, out_level_ff};
         REG_MONO_SUM:  prdata = {31'd0, mono_ff};
      endcase
   end

   // program fetch and handshake
   assign uc         = ucode_rom(step_ff);
   assign req_stall  = (uc.cond != COND_ITEM);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign produce    = !mono_ff || last_ff;
   assign publish    = (uc.cond == COND_PUBLISH) && rsp_free;

   // step counter with conditional jumps
   always_comb begin
      step_in = step_ff;
      unique case (uc.cond)
         COND_NONE:    step_in = STEP_W'(step_ff + 1'b1);
         COND_ITEM:    if (req_accept) step_in = STEP_W'(1);
         COND_PUBLISH: if (rsp_free) step_in = '0;
         default:      step_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) step_ff <= '0;
      else step_ff <= step_in;
   end

   // item capture
   always_ff @(posedge clock) begin
      if (req_accept) begin
         audio_ff <= req_audio_in;
         x_cv_ff  <= req_x_cv;
         y_cv_ff  <= req_y_cv;
         z_cv_ff  <= req_z_cv;
         last_ff  <= req_last_channel;
      end
   end

   // axis complements
   assign wx0 = POS_ONE - px_ff;
   assign wy0 = POS_ONE - py_ff;
   assign wz0 = POS_ONE - pz_ff;

   // multiplier operand a
   always_comb begin
      unique case (uc.mul_a)
         A_CVX:   a_op = {{18{x_cv_ff[15]}}, x_cv_ff};
         A_CVY:   a_op = {{18{y_cv_ff[15]}}, y_cv_ff};
         A_CVZ:   a_op = {{18{z_cv_ff[15]}}, z_cv_ff};
         A_AUDIO: a_op = {{18{audio_ff[15]}}, audio_ff};
         A_WX0:   a_op = {17'd0, wx0};
         A_WX1:   a_op = {17'd0, px_ff};
         A_S:     a_op = {{17{s_ff[16]}}, s_ff};
         A_U0:    a_op = u_ff[0];
         A_U1:    a_op = u_ff[1];
         default: a_op = '0;
      endcase
   end

   // multiplier operand b
   always_comb begin
      unique case (uc.mul_b)
         B_AX:    b_op = {{2{x_amount_ff[15]}}, x_amount_ff};
         B_AY:    b_op = {{2{y_amount_ff[15]}}, y_amount_ff};
         B_AZ:    b_op = {{2{z_amount_ff[15]}}, z_amount_ff};
         B_LVL:   b_op = {2'd0, out_level_ff};
         B_WY0:   b_op = {1'b0, wy0};
         B_WY1:   b_op = {1'b0, py_ff};
         B_WZ0:   b_op = {1'b0, wz0};
         B_WZ1:   b_op = {1'b0, pz_ff};
         B_WXY0:  b_op = {1'b0, wxy_ff[0]};
         B_WXY1:  b_op = {1'b0, wxy_ff[1]};
         B_WXY2:  b_op = {1'b0, wxy_ff[2]};
         B_WXY3:  b_op = {1'b0, wxy_ff[3]};
         default: b_op = '0;
      endcase
   end

   // shared multiplier, product registered
   assign prod_in = a_op * b_op;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // round to nearest with one shared bias add
   always_comb begin
      unique case (uc.wb)
         WB_POS:    bias = 52'sd8192;
         WB_CORNER: bias = 52'sd2147483648;
         default:   bias = 52'sd32768;
      endcase
      rnd_sum = prod_ff + bias;
      sh14    = rnd_sum >>> 14;
      sh16    = rnd_sum >>> 16;
      sh32    = rnd_sum >>> 32;
   end

   // axis position: base plus cv offset, clamped to the unit range
   always_comb begin
      unique case (uc.wb_idx[1:0])
         2'd0:    base_sel = x_base_ff;
         2'd1:    base_sel = y_base_ff;
         default: base_sel = z_base_ff;
      endcase
      pos_sum = $signed({3'b000, base_sel}) + sh14[18:0];
      if (pos_sum < 19'sd0) pos_in = '0;
      else if (pos_sum > 19'sd65536) pos_in = POS_ONE;
      else pos_in = pos_sum[16:0];
   end

   // corner sample saturated to 16 bits
   always_comb begin
      corner_raw = sh32[19:0];
      if (corner_raw > 20'sd32767) c_in = 16'sh7FFF;
      else if (corner_raw < -20'sd32768) c_in = -16'sd32768;
      else c_in = corner_raw[15:0];
   end

   // product write-back
   always_ff @(posedge clock) begin
      unique case (uc.wb)
         WB_POS: begin
            unique case (uc.wb_idx[1:0])
               2'd0:    px_ff <= pos_in;
               2'd1:    py_ff <= pos_in;
               default: pz_ff <= pos_in;
            endcase
         end
         WB_SCALE:  s_ff <= sh16[16:0];
         WB_WXY:    wxy_ff[uc.wb_idx[1:0]] <= sh16[16:0];
         WB_U:      u_ff[uc.wb_idx[0]] <= prod_ff[33:0];
         WB_CORNER: c_ff <= c_in;
         default: ;
      endcase
   end

   // frame accumulation and result selection
   always_comb begin
      acc_sum = {acc_ff[uc.acc_idx][ACC_W-1], acc_ff[uc.acc_idx]}
              + {{5{c_ff[15]}}, c_ff};
      acc_in  = '0;
      res_in  = c_ff;
      res_we  = 1'b0;
      if (!mono_ff) begin
         res_we = 1'b1;
      end else if (!last_ff) begin
         if (acc_sum > 21'sd524287) acc_in = 20'sd524287;
         else if (acc_sum < -21'sd524288) acc_in = -20'sd524288;
         else acc_in = acc_sum[ACC_W-1:0];
      end else begin
         res_we = 1'b1;
         if (acc_sum > 21'sd32767) res_in = 16'sh7FFF;
         else if (acc_sum < -21'sd32768) res_in = -16'sd32768;
         else res_in = acc_sum[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) acc_ff[i] <= '0;
      end else if (uc.acc_en) begin
         acc_ff[uc.acc_idx] <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (uc.acc_en && res_we) res_ff[uc.acc_idx] <= res_in;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (publish) rsp_valid_in = produce;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (publish && produce) begin
         for (int i = 0; i < 8; i++) out_ff[i] <= res_ff[i];
         frame_end_ff <= last_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_bottom_left_front  = out_ff[0];
   assign rsp_bottom_right_front = out_ff[1];
   assign rsp_top_left_front     = out_ff[2];
   assign rsp_top_right_front    = out_ff[3];
   assign rsp_bottom_left_back   = out_ff[4];
   assign rsp_bottom_right_back  = out_ff[5];
   assign rsp_top_left_back      = out_ff[6];
   assign rsp_top_right_back     = out_ff[7];
   assign rsp_frame_end          = frame_end_ff;

endmodule

>>> tb/tb.sv
// self-checking testbench of the eight-way trilinear panner: directed and random traffic against a predictor
`timescale 1ns / 1ps

module tb;
   import tpew_pkg::*;

   localparam int DRAIN_CYCLES = 40;
   localparam int IDLE_LIMIT = 4000;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 45;

   // one channel item as sent to the block
   typedef struct packed {
      logic signed [15:0] audio;
      logic signed [15:0] x_cv;
      logic signed [15:0] y_cv;
      logic signed [15:0] z_cv;
      logic               last;
   } channel_sample_type;

   // eight corner samples plus the frame mark, index bits: x right, y top, z back
   typedef struct packed {
      logic [7:0][15:0] corner;
      logic             frame_end;
   } corner_mix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_audio_in = '0;
   logic signed [15:0] req_x_cv = '0;
   logic signed [15:0] req_y_cv = '0;
   logic signed [15:0] req_z_cv = '0;
   logic               req_last_channel = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_bottom_left_front;
   logic signed [15:0] rsp_bottom_right_front;
   logic signed [15:0] rsp_top_left_front;
   logic signed [15:0] rsp_top_right_front;
   logic signed [15:0] rsp_bottom_left_back;
   logic signed [15:0] rsp_bottom_right_back;
   logic signed [15:0] rsp_top_left_back;
   logic signed [15:0] rsp_top_right_back;
   logic               rsp_frame_end;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [4:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   // shadow copy of the register file
   logic [15:0]        cfg_x_base = 16'd32768;
   logic [15:0]        cfg_y_base = 16'd32768;
   logic [15:0]        cfg_z_base = 16'd32768;
   logic signed [15:0] cfg_x_amount = '0;
   logic signed [15:0] cfg_y_amount = '0;
   logic signed [15:0] cfg_z_amount = '0;
   logic [15:0]        cfg_out_level = 16'd65535;
   logic               cfg_mono_sum = 1'b0;

   // predicted mono accumulators
   longint corner_acc [8];

   channel_sample_type pending_samples [$];
   corner_mix_type     expected_mixes [$];
   string              corner_names [8];

   int mismatches = 0;
   int samples_sent = 0;
   int mixes_checked = 0;
   int frames_closed = 0;
   int reg_writes = 0;
   int settings_run = 0;
   int burst_left = 1;
   int gap_left = 0;
   int stall_mode = 0;
   int stall_timer = 0;
   int idle_cycles = 0;

   trilinear_panner_eight_way_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_audio_in(req_audio_in),
      .req_x_cv(req_x_cv),
      .req_y_cv(req_y_cv),
      .req_z_cv(req_z_cv),
      .req_last_channel(req_last_channel),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_bottom_left_front(rsp_bottom_left_front),
      .rsp_bottom_right_front(rsp_bottom_right_front),
      .rsp_top_left_front(rsp_top_left_front),
      .rsp_top_right_front(rsp_top_right_front),
      .rsp_bottom_left_back(rsp_bottom_left_back),
      .rsp_bottom_right_back(rsp_bottom_right_back),
      .rsp_top_left_back(rsp_top_left_back),
      .rsp_top_right_back(rsp_top_right_back),
      .rsp_frame_end(rsp_frame_end),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // floor((v + 2^(k-1)) / 2^k)
   function automatic longint round_shift(input longint v, input int k);
      return (v + (longint'(1) <<< (k - 1))) >>> k;
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // axis position in Q1.16, 65536 is full scale
   function automatic longint axis_position(input logic [15:0] base,
                                            input logic signed [15:0] amount,
                                            input logic signed [15:0] cv);
      longint offset;
      offset = round_shift(longint'(cv) * longint'(amount), 14);
      return clamp(longint'(base) + offset, 0, 65536);
   endfunction

   // pans one channel item, updates the mono sums, returns 1 when a mix comes out
   function automatic bit pan_channel(input channel_sample_type it,
                                      output corner_mix_type mix);
      longint px, py, pz, s, wxy, c;
      longint wx [2];
      longint wy [2];
      longint wz [2];
      longint corner [8];
      int i;
      px = axis_position(cfg_x_base, cfg_x_amount, it.x_cv);
      py = axis_position(cfg_y_base, cfg_y_amount, it.y_cv);
      pz = axis_position(cfg_z_base, cfg_z_amount, it.z_cv);
      wx[0] = 65536 - px; wx[1] = px;
      wy[0] = 65536 - py; wy[1] = py;
      wz[0] = 65536 - pz; wz[1] = pz;
      s = round_shift(longint'(it.audio) * longint'(cfg_out_level), 16);
      mix = '0;
      for (i = 0; i < 8; i++) begin
         wxy = round_shift(wx[i & 1] * wy[(i >> 1) & 1], 16);
         c = round_shift(s * wxy * wz[(i >> 2) & 1], 32);
         corner[i] = clamp(c, -32768, 32767);
      end
      // poly mode: every item gives a mix, sums stay clear
      if (!cfg_mono_sum) begin
         for (i = 0; i < 8; i++) begin
            corner_acc[i] = 0;
            mix.corner[i] = 16'(corner[i]);
         end
         mix.frame_end = it.last;
         return 1'b1;
      end
      // mono mode, inside a frame: accumulate with 20-bit saturation
      if (!it.last) begin
         for (i = 0; i < 8; i++)
            corner_acc[i] = clamp(corner_acc[i] + corner[i], -524288, 524287);
         return 1'b0;
      end
      // mono mode, last channel closes the frame
      for (i = 0; i < 8; i++) begin
         mix.corner[i] = 16'(clamp(corner_acc[i] + corner[i], -32768, 32767));
         corner_acc[i] = 0;
      end
      mix.frame_end = 1'b1;
      return 1'b1;
   endfunction

   function automatic void note_mismatch(input string what, input longint want,
                                         input longint got);
      if (mismatches < 10)
         $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
      mismatches++;
   endfunction

   // random half the time, a corner value otherwise
   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_sample(input logic [15:0] audio, input logic [15:0] x_cv,
                               input logic [15:0] y_cv, input logic [15:0] z_cv,
                               input logic last);
      channel_sample_type it;
      it.audio = audio;
      it.x_cv = x_cv;
      it.y_cv = y_cv;
      it.z_cv = z_cv;
      it.last = last;
      pending_samples.push_back(it);
   endtask

   // mostly whole frames, some with a broken last mark
   task automatic queue_random_frames(input int count);
      int n, len, k;
      bit broken;
      n = 0;
      while (n < count) begin
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 16);
         broken = ($urandom_range(0, 9) == 0);
         for (k = 0; k < len; k++)
            queue_sample(pick16(), pick16(), pick16(), pick16(),
                         broken ? 1'($urandom_range(0, 1)) : (k == len - 1));
         n += len;
      end
   endtask

   // apb write: setup, then access; upper data bits carry noise
   task automatic write_reg(input reg_idx_type idx, input logic [15:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= {16'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_X_BASE:    cfg_x_base = value;
         REG_Y_BASE:    cfg_y_base = value;
         REG_Z_BASE:    cfg_z_base = value;
         REG_X_AMOUNT:  cfg_x_amount = value;
         REG_Y_AMOUNT:  cfg_y_amount = value;
         REG_Z_AMOUNT:  cfg_z_amount = value;
         REG_OUT_LEVEL: cfg_out_level = value;
         default:       cfg_mono_sum = value[0];
      endcase
      reg_writes++;
   endtask

   task automatic write_all(input logic [15:0] xb, input logic [15:0] yb,
                            input logic [15:0] zb, input logic [15:0] xa,
                            input logic [15:0] ya, input logic [15:0] za,
                            input logic [15:0] lvl, input logic [15:0] mono);
      write_reg(REG_X_BASE, xb);
      write_reg(REG_Y_BASE, yb);
      write_reg(REG_Z_BASE, zb);
      write_reg(REG_X_AMOUNT, xa);
      write_reg(REG_Y_AMOUNT, ya);
      write_reg(REG_Z_AMOUNT, za);
      write_reg(REG_OUT_LEVEL, lvl);
      write_reg(REG_MONO_SUM, mono);
      settings_run++;
   endtask

   // block idle: all items taken, all mixes back, then let the pipeline run dry
   task automatic wait_idle();
      @(posedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_mixes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // sender: bursts of items with random gaps, payload held while stalled
   always @(posedge clock) begin : sender
      channel_sample_type nxt, cur;
      corner_mix_type mix;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            cur = {req_audio_in, req_x_cv, req_y_cv, req_z_cv, req_last_channel};
            samples_sent++;
            if (pan_channel(cur, mix))
               expected_mixes.push_back(mix);
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               nxt = pending_samples.pop_front();
               req_audio_in <= nxt.audio;
               req_x_cv <= nxt.x_cv;
               req_y_cv <= nxt.y_cv;
               req_z_cv <= nxt.z_cv;
               req_last_channel <= nxt.last;
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall: free, random, heavy or periodic, switching now and then
   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode <= 0;
         stall_timer <= 0;
      end else begin
         if (stall_timer == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_timer <= $urandom_range(20, 150);
         end else begin
            stall_timer <= stall_timer - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 1) == 1);
            2: rsp_stall <= ($urandom_range(0, 7) != 0);
            default: rsp_stall <= stall_timer[3];
         endcase
      end
   end

   // result check against the oldest predicted mix
   always @(posedge clock) begin : monitor
      corner_mix_type got, want;
      int i;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.corner = {rsp_top_right_back, rsp_top_left_back, rsp_bottom_right_back,
                       rsp_bottom_left_back, rsp_top_right_front, rsp_top_left_front,
                       rsp_bottom_right_front, rsp_bottom_left_front};
         got.frame_end = rsp_frame_end;
         mixes_checked++;
         if (got.frame_end) frames_closed++;
         if (expected_mixes.size() == 0) begin
            note_mismatch("unexpected item, frame_end", -1, got.frame_end);
         end else begin
            want = expected_mixes.pop_front();
            for (i = 0; i < 8; i++)
               if (got.corner[i] !== want.corner[i])
                  note_mismatch(corner_names[i], $signed(want.corner[i]),
                                $signed(got.corner[i]));
            if (got.frame_end !== want.frame_end)
               note_mismatch("frame_end", want.frame_end, got.frame_end);
         end
      end
   end

   // watchdog on cycles where nothing moves
   always @(posedge clock) begin : watchdog
      if (reset || psel || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: nothing accepted for %0d cycles, %0d items pending, %0d mixes due",
                  idle_cycles, pending_samples.size(), expected_mixes.size());
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus sequence
   initial begin : stimulus
      int p, k;
      corner_names = '{"bottom_left_front", "bottom_right_front", "top_left_front",
                       "top_right_front", "bottom_left_back", "bottom_right_back",
                       "top_left_back", "top_right_back"};
      for (k = 0; k < 8; k++) corner_acc[k] = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset defaults, poly: sample extremes, cv has no effect
      queue_sample(16'h0000, 16'h7fff, 16'h8000, 16'h0000, 1'b0);
      queue_sample(16'h7fff, 16'h8000, 16'h7fff, 16'hffff, 1'b1);
      queue_sample(16'h8000, 16'hffff, 16'h0000, 16'h7fff, 1'b0);
      wait_idle();

      // base and depth extremes, positions clamp at both ends
      write_all(16'h0000, 16'hffff, 16'd12345, 16'h7fff, 16'h8000, 16'h4000,
                16'hffff, 16'h0000);
      queue_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
      queue_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
      queue_sample(16'h7fff, 16'h0000, 16'hffff, 16'h0001, 1'b0);
      queue_sample(16'hffff, 16'h4000, 16'hc000, 16'h8000, 1'b1);
      queue_sample(16'h0001, 16'h7fff, 16'h0000, 16'hffff, 1'b0);
      wait_idle();
      write_reg(REG_OUT_LEVEL, 16'h0000);
      queue_sample(16'h7fff, 16'h1234, 16'h8000, 16'h7fff, 1'b1);
      wait_idle();

      // mono: a frame too long for the sums, all weight on one corner
      write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                16'hffff, 16'h0001);
      for (k = 0; k < 17; k++) queue_sample(16'h7fff, pick16(), pick16(), pick16(), 1'b0);
      queue_sample(16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
      wait_idle();

      // mono frame left open, then switched to poly and back
      write_reg(REG_X_BASE, 16'h8000);
      queue_sample(16'h4000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      queue_sample(16'hc000, 16'h7fff, 16'h8000, 16'h7fff, 1'b0);
      wait_idle();
      write_reg(REG_MONO_SUM, 16'h0000);
      queue_sample(16'h2000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      wait_idle();
      write_reg(REG_MONO_SUM, 16'hfff1);
      queue_sample(16'h3000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      queue_sample(16'h3000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
      wait_idle();

      // random register settings with random frames
      for (p = 0; p < RANDOM_PHASES; p++) begin
         write_all(pick16(), pick16(), pick16(), pick16(), pick16(), pick16(), pick16(),
                   16'($urandom));
         queue_random_frames(ITEMS_PER_PHASE);
         wait_idle();
      end

      $display("ran %0d channel items over %0d register settings (%0d writes)",
               samples_sent, settings_run, reg_writes);
      $display("checked %0d corner mixes, %0d of them closing a frame, %0d mismatches",
               mixes_checked, frames_closed, mismatches);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/tpew_pkg.sv
hdl/trilinear_panner_eight_way_unit.sv
tb/tb.sv
